FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; assertions compile out when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("fail");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/fa2_pkg.sv
// Shared types and constants for the fixed-point atan2 unit.
// No dependencies.
`default_nettype none
package fa2_pkg;
  localparam int IN_W = 16;
  localparam int MAG_W = IN_W;          // magnitude of a signed IN_W value fits IN_W bits
  localparam int Q_W = 15;              // Q0.15 ratio
  localparam int DIV_STEPS = Q_W + 1;   // quotient bits 15..0
  localparam logic [15:0] Q_C1 = 16'd31863;
  localparam logic [15:0] Q_C2 = 16'd6290;
  localparam logic signed [15:0] Q_PI = 16'sd25736;
  localparam logic signed [15:0] Q_HALF_PI = 16'sd12868;
  localparam logic [15:0] Q_SAT = 16'd32767;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    K_ZERO,     // result fixed, no ratio needed
    K_XMAJOR,   // |x| > |y|: ratio y/x
    K_YMAJOR    // ratio x/y against +-pi/2
  } kind_t;

  // classified transaction passed from front to back
  typedef struct packed {
    kind_t             kind;
    logic [MAG_W-1:0]  num;
    logic [MAG_W-1:0]  den;
    logic              neg;    // sign of ratio
    logic signed [15:0] offs;  // constant term added at the end
    logic              sub;    // result = offs - a (else offs + a)
  } job_t;
endpackage
`default_nettype wire

FILE: rtl/fa2_front.sv
// Front stage: magnitudes and octant classification.
// Depends on fa2_pkg.
`default_nettype none
module fa2_front import fa2_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [IN_W-1:0]   in_x_comp,
  input  wire logic [IN_W-1:0]   in_y_comp,
  output logic                   f_valid,
  input  wire logic              f_stall,
  output job_t                   f_job
);
  logic signed [IN_W-1:0] x, y;
  logic [MAG_W-1:0] ax, ay;
  job_t job_nxt, job_r;
  logic valid_r;

  assign x  = in_x_comp;
  assign y  = in_y_comp;
  assign ax = x[IN_W-1] ? MAG_W'(-x) : MAG_W'(x);
  assign ay = y[IN_W-1] ? MAG_W'(-y) : MAG_W'(y);

  always_comb begin
    job_nxt      = '0;
    job_nxt.kind = K_ZERO;
    if (x != '0) begin
      if (ax > ay) begin
        job_nxt.kind = K_XMAJOR;
        job_nxt.num  = ay;
        job_nxt.den  = ax;
        job_nxt.neg  = (y != '0) && (x[IN_W-1] != y[IN_W-1]);
        job_nxt.sub  = 1'b0;
        if (x[IN_W-1]) job_nxt.offs = y[IN_W-1] ? -Q_PI : Q_PI;
        else           job_nxt.offs = '0;
      end else begin
        job_nxt.kind = K_YMAJOR;
        job_nxt.num  = ax;
        job_nxt.den  = ay;
        job_nxt.neg  = x[IN_W-1] != y[IN_W-1];
        job_nxt.sub  = 1'b1;
        job_nxt.offs = y[IN_W-1] ? -Q_HALF_PI : Q_HALF_PI;
      end
    end else if (y != '0) begin
      job_nxt.offs = y[IN_W-1] ? -Q_HALF_PI : Q_HALF_PI;
    end
  end

  assign in_stall = valid_r && f_stall;
  assign f_valid  = valid_r;
  assign f_job    = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
    if (!in_stall && in_valid) job_r <= job_nxt;
  end
endmodule
`default_nettype wire

FILE: rtl/fa2_fifo.sv
// Short queue decoupling the front and back stages.
// Depends on fa2_pkg.
`default_nettype none
module fa2_fifo import fa2_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_stall,
  input  wire job_t wr_job,
  output logic      rd_valid,
  input  wire logic rd_stall,
  output job_t      rd_job
);
  localparam int PW = $clog2(FIFO_DEPTH);
  job_t mem_r [FIFO_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0] cnt_r;
  logic wr, rd;

  assign wr_stall = (cnt_r == (PW+1)'(FIFO_DEPTH));
  assign rd_valid = cnt_r != '0;
  assign rd_job   = mem_r[rp_r];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr) - (PW+1)'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_job;
  end
endmodule
`default_nettype wire

FILE: rtl/fa2_back.sv
// Back stage: pipelined restoring divider, polynomial and quadrant fix-up.
// Depends on fa2_pkg.
`default_nettype none
module fa2_back import fa2_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        b_valid,
  output logic             b_stall,
  input  wire job_t        b_job,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_angle
);
  localparam int NS = DIV_STEPS + 6;   // input, divider steps, m, z2, p, p*m, final
  localparam int RW = MAG_W + 1;

  logic adv;
  logic [NS-1:0] v_r;
  job_t          job_r [NS];
  logic [RW-1:0] rem_r [DIV_STEPS+1];
  logic [15:0]   q_r   [DIV_STEPS+1];
  logic [15:0]   m_r, z2_r, p_r;
  logic [31:0]   pm_r;
  logic [15:0]   ang_r;

  assign adv     = !(v_r[NS-1] && out_stall);
  assign b_stall = !adv;
  assign out_valid = v_r[NS-1];
  assign out_angle = ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], b_valid};
    end
  end

  // divider: one quotient bit per stage, bit 15 first
  always_ff @(posedge clk) begin
    if (adv) begin
      job_r[0] <= b_job;
      rem_r[0] <= RW'(b_job.num);
      q_r[0]   <= '0;
      for (int i = 1; i < NS; i++) job_r[i] <= job_r[i-1];
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    logic [RW:0] sh;
    logic [RW:0] df;
    assign sh = {rem_r[s], 1'b0};
    assign df = sh - (RW+1)'(job_r[s].den);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (s == 0) begin
          // bit 15 = num >= den: compare without shift
          rem_r[s+1] <= (rem_r[s] >= RW'(job_r[s].den)) ?
                        rem_r[s] - RW'(job_r[s].den) : rem_r[s];
          q_r[s+1]   <= {(rem_r[s] >= RW'(job_r[s].den)), 15'd0};
        end else begin
          rem_r[s+1] <= df[RW] ? sh[RW-1:0] : df[RW-1:0];
          q_r[s+1]   <= q_r[s] | (16'(!df[RW]) << (DIV_STEPS-1-s));
        end
      end
    end
  end

  logic [15:0] qsat;
  logic [31:0] mm, c2z;
  assign qsat = (q_r[DIV_STEPS] > Q_SAT) ? Q_SAT : q_r[DIV_STEPS];
  assign mm   = 32'(m_r) * 32'(m_r);
  assign c2z  = 32'(Q_C2) * 32'(z2_r);

  logic signed [16:0] a_s, r_s;
  job_t jf;
  assign jf  = job_r[NS-2];
  assign a_s = jf.neg ? -17'(pm_r[31:17]) : 17'(pm_r[31:17]);
  always_comb begin
    if (jf.kind == K_ZERO) r_s = 17'(jf.offs);
    else if (jf.sub)       r_s = 17'(jf.offs) - a_s;
    else                   r_s = 17'(jf.offs) + a_s;
  end

  logic [15:0] m2_r, m3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      m_r   <= (job_r[DIV_STEPS].num == '0) ? '0 : qsat;
      z2_r  <= mm[30:15];
      m2_r  <= m_r;
      p_r   <= Q_C1 - c2z[30:15];
      m3_r  <= m2_r;
      pm_r  <= 32'(p_r) * 32'(m3_r) + 32'h0001_0000;
      ang_r <= r_s[15:0];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/fast_atan2_polynomial_unit.sv
// Four-quadrant fixed-point atan2: Q3.13 angle from 16-bit signed (x, y).
// One transaction per cycle sustained while out_stall is low.
// Most of the pipeline depth is the 16-stage pipelined restoring divider in the back stage.
// Front classifies into a 2-entry queue; the back pipeline halts while its result waits.
// Reset: synchronous active-low rst_n empties front, queue and pipeline valid bits.
// Depends on fa2_pkg, fa2_front, fa2_fifo, fa2_back, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fast_atan2_polynomial_unit import fa2_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [IN_W-1:0] in_x_comp,
  input  wire logic [IN_W-1:0] in_y_comp,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [15:0]          out_angle
);
  logic f_valid, f_stall, q_valid, q_stall;
  job_t f_job, q_job;

  // front: magnitudes, octant, constant offset
  fa2_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_x_comp, .in_y_comp,
    .f_valid, .f_stall, .f_job
  );

  // queue lets the front keep taking transactions during a short back stall
  fa2_fifo u_fifo (
    .clk, .rst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_job(f_job),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_job(q_job)
  );

  // back: divider, polynomial, fix-up
  fa2_back u_back (
    .clk, .rst_n, .b_valid(q_valid), .b_stall(q_stall), .b_job(q_job),
    .out_valid, .out_stall, .out_angle
  );

  `ASSERT_IMPLIES(a_range, clk, rst_n, out_valid,
    ($signed(out_angle) <= Q_PI) && ($signed(out_angle) >= -Q_PI))
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_angle))
  `ASSERT_IMPLIES(a_qstall, clk, rst_n, q_stall, out_valid && out_stall)
endmodule
`default_nettype wire
